FILE: src/stable_sorted_priority_queue_assert.svh
// Assertion macros for the stable sorted priority queue checker.
// Depends on nothing; included by the checker file.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Clocked assertion, ignored while reset is high.
`define STSQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define STSQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/stsq_pkg.sv
// Shared types and constants for the stable sorted priority queue.
// Used by the cell, the top level and the checker; depends on nothing.
`default_nettype none

package stsq_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int PRIO_W           = 8;
   localparam int PAYLOAD_W        = 32;
   localparam int OCC_W            = 5;

   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_DEQUEUE = 1'b1;

   typedef struct packed {
      logic                 func;
      logic [PRIO_W-1:0]    priority_req;
      logic [PAYLOAD_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic                 queue_empty;
      logic [PRIO_W-1:0]    front_priority;
      logic [PAYLOAD_W-1:0] front_payload;
      logic [OCC_W-1:0]     occupancy;
      logic                 refused;
   } rsp_type;

   typedef struct packed {
      logic [PRIO_W-1:0]    prio;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type item;
   } cmd_type;

endpackage

`default_nettype wire

FILE: src/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue: a chain of stsq_cell slots,
// the occupancy count and the result register. Depends on stsq_pkg, stsq_cell.
//
// Holds up to CAPACITY entries sorted by ascending priority; equal priorities
// leave in arrival order. Each request transfer either enqueues an entry or
// dequeues the front one, and yields exactly one response transfer reporting
// the front entry, emptiness and occupancy after the operation. Every cell
// compares against the new priority in parallel and all cells shift together,
// so a new request is taken every cycle while the response register is free
// or being drained. An enqueue into a full queue is dropped and flagged with
// refused; a dequeue of an empty queue changes nothing. occupancy reports
// the count modulo 32.
`default_nettype none

module stable_sorted_priority_queue #(
   parameter int CAPACITY = stsq_pkg::CAPACITY_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire stsq_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output stsq_pkg::rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   stsq_pkg::rsp_type rsp_ff;
   stsq_pkg::rsp_type rsp_in;

   logic              req_fire;
   logic              full;
   logic              empty;
   stsq_pkg::cmd_type cmd;

   logic                cell_keep  [CAPACITY];
   stsq_pkg::entry_type cell_entry [CAPACITY];
   stsq_pkg::entry_type cell_next  [CAPACITY];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   always_comb begin
      cmd.item.prio    = req_data.priority_req;
      cmd.item.payload = req_data.payload;
      cmd.enq = req_fire && (req_data.func == stsq_pkg::FUNC_ENQUEUE) && !full;
      cmd.deq = req_fire && (req_data.func == stsq_pkg::FUNC_DEQUEUE) && !empty;
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic                left_keep;
      stsq_pkg::entry_type left_entry;
      stsq_pkg::entry_type right_entry;

      if (g == 0) begin : g_head
         assign left_keep  = 1'b1;
         assign left_entry = cmd.item;
      end else begin : g_body
         assign left_keep  = cell_keep[g-1];
         assign left_entry = cell_entry[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         assign right_entry = cmd.item;
      end else begin : g_mid
         assign right_entry = cell_entry[g+1];
      end

      stsq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (CNT_W'(g) < count_ff),
         .left_keep   (left_keep),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .keep        (cell_keep[g]),
         .entry       (cell_entry[g]),
         .next_entry  (cell_next[g])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.enq) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_in                = rsp_ff;
      rsp_valid_in          = rsp_valid_ff && rsp_stall;
      if (req_fire) begin
         rsp_valid_in          = 1'b1;
         rsp_in.queue_empty    = (count_in == '0);
         rsp_in.front_priority = (count_in == '0) ? '0 : cell_next[0].prio;
         rsp_in.front_payload  = (count_in == '0) ? '0 : cell_next[0].payload;
         rsp_in.occupancy      = stsq_pkg::OCC_W'(count_in);
         rsp_in.refused        = (req_data.func == stsq_pkg::FUNC_ENQUEUE) && full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: src/stsq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// Depends on stsq_pkg.
`default_nettype none

module stsq_cell (
   input  wire logic                clock,
   input  wire stsq_pkg::cmd_type   cmd,
   input  wire logic                occupied,
   input  wire logic                left_keep,
   input  wire stsq_pkg::entry_type left_entry,
   input  wire stsq_pkg::entry_type right_entry,
   output logic                     keep,
   output stsq_pkg::entry_type      entry,
   output stsq_pkg::entry_type      next_entry
);

   stsq_pkg::entry_type entry_ff;
   stsq_pkg::entry_type entry_in;

   assign keep = occupied && (entry_ff.prio <= cmd.item.prio);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.enq) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = cmd.item;
         end else begin
            entry_in = left_entry;
         end
      end else if (cmd.deq) begin
         entry_in = right_entry;
      end
   end

   assign entry      = entry_ff;
   assign next_entry = entry_in;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

FILE: src/stsq_checker.sv
// Port-level checker for the stable sorted priority queue, bound to the top.
// Depends on stsq_pkg and stable_sorted_priority_queue_assert.svh.
`default_nettype none

`include "stable_sorted_priority_queue_assert.svh"

module stsq_checker #(
   parameter int CAPACITY = stsq_pkg::CAPACITY_DEFAULT
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire stsq_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire stsq_pkg::rsp_type rsp_data
);

   localparam logic [stsq_pkg::OCC_W-1:0] FULL_OCC = stsq_pkg::OCC_W'(CAPACITY);

   `STSQ_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data),
      "stalled response changed")
   `STSQ_ASSERT(a_one_rsp, clock, reset,
      req_valid && !req_stall |=> rsp_valid,
      "request transfer gave no response")
   `STSQ_ASSERT(a_refused_full, clock, reset,
      rsp_valid && rsp_data.refused |->
         rsp_data.occupancy == FULL_OCC && !rsp_data.queue_empty,
      "refusal while not full")
   `STSQ_ASSERT(a_empty_front, clock, reset,
      rsp_valid && rsp_data.queue_empty |->
         rsp_data.front_priority == '0 && rsp_data.front_payload == '0 &&
         !rsp_data.refused,
      "empty queue reports a front entry")
   `STSQ_ASSERT_ALWAYS(a_reset_idle, clock,
      reset |=> !rsp_valid,
      "response valid right after reset")

endmodule

bind stable_sorted_priority_queue stsq_checker #(.CAPACITY(CAPACITY)) u_stsq_checker (.*);

`default_nettype wire
